// File: rtl/core/tks_pkg.sv
// Shared widths and types for the top-K score selector.
package tks_pkg;

  localparam int SCORE_W = 32;
  localparam int IDX_W   = 10;
  localparam int RANK_W  = 3;
  localparam int TOPC_W  = 4;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic        [IDX_W-1:0]   label_idx_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic occupied;
    logic first_free;
    logic in_range;
  } cell_ctl_t;

endpackage

// File: rtl/core/tks_if.sv
// Valid/ready stream interfaces for score beats and result beats.
interface tks_in_if;
  logic                  valid;
  logic                  ready;
  tks_pkg::score_t       score;
  logic                  end_of_vector;

  modport source (output valid, output score, output end_of_vector, input ready);
  modport sink   (input valid, input score, input end_of_vector, output ready);
endinterface

interface tks_out_if;
  logic                        valid;
  logic                        ready;
  tks_pkg::label_idx_t         label_index;
  logic [tks_pkg::RANK_W-1:0]  rank;
  logic                        last_of_run;
  logic                        overflowed;

  modport source (output valid, output label_index, output rank, output last_of_run,
                  output overflowed, input ready);
  modport sink   (input valid, input label_index, input rank, input last_of_run,
                  input overflowed, output ready);
endinterface

// File: rtl/core/tks_cell.sv
// One slot of the sorted list: inserts, shifts down on insertion, shifts up on drain.
module tks_cell (
  input  logic                clk,
  input  tks_pkg::cell_ctl_t  ctl,
  input  tks_pkg::score_t     new_score,
  input  tks_pkg::label_idx_t new_idx,
  input  logic                prev_beaten,
  input  tks_pkg::score_t     prev_score,
  input  tks_pkg::label_idx_t prev_idx,
  input  tks_pkg::score_t     next_score,
  input  tks_pkg::label_idx_t next_idx,
  output tks_pkg::score_t     score,
  output tks_pkg::label_idx_t idx,
  output logic                beaten
);

  tks_pkg::score_t     score_r;
  tks_pkg::label_idx_t idx_r;
  logic                take_prev;
  logic                take_new;

  assign beaten    = ctl.occupied && (score_r < new_score);
  assign take_prev = ctl.insert && ctl.in_range && prev_beaten;
  assign take_new  = ctl.insert && ctl.in_range && !prev_beaten && (beaten || ctl.first_free);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      score_r <= next_score;
      idx_r   <= next_idx;
    end else if (take_prev) begin
      score_r <= prev_score;
      idx_r   <= prev_idx;
    end else if (take_new) begin
      score_r <= new_score;
      idx_r   <= new_idx;
    end
  end

  assign score = score_r;
  assign idx   = idx_r;

endmodule

// File: rtl/core/top_k_score_selector.sv
// Top level of the streaming top-K score selector.
// Scores enter one beat per cycle and are sorted on arrival into a chain of TOP_MAX cells,
// highest first, with the lower label index kept ahead on equal scores. The beat marked
// end_of_vector is inserted like the others; then the block shifts the chain up through its
// first cell into the output register, one reported index at a time, waiting while a held
// result beat is not taken, and takes no score beat until the last index is out. At most
// top_count indices are reported, capped at TOP_MAX, and one when top_count is zero.
// Scores past MAX_LABELS in one vector are dropped and set overflowed on all its result beats.
module top_k_score_selector #(
  parameter int TOP_MAX    = 8,
  parameter int MAX_LABELS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tks_in_if.sink                      in_ch,
  tks_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tks_pkg::TOPC_W-1:0]  cfg_wdata
);

  localparam int KW    = $clog2(TOP_MAX + 1);
  localparam int CNT_W = $clog2(MAX_LABELS + 1);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_DRAIN  = 1'b1;

  logic                       state_r;
  logic [tks_pkg::TOPC_W-1:0] top_count_r;
  logic [KW-1:0]              filled_r;
  logic [CNT_W-1:0]           label_cnt_r;
  logic                       ovf_r;
  logic [KW-1:0]              emit_n_r;
  logic                       emit_ovf_r;
  logic [KW-1:0]              rank_r;

  logic                       out_valid_r;
  tks_pkg::label_idx_t        out_idx_r;
  logic [tks_pkg::RANK_W-1:0] out_rank_r;
  logic                       out_last_r;
  logic                       out_ovf_r;

  logic [KW-1:0]              k_eff;
  logic [KW-1:0]              n_cur;
  logic [KW-1:0]              fill_nxt;
  logic                       accept;
  logic                       cnt_ok;
  logic                       insert;
  logic                       load_out;
  logic                       drain_last;
  tks_pkg::label_idx_t        new_idx;

  tks_pkg::score_t            cell_score [TOP_MAX];
  tks_pkg::label_idx_t        cell_idx   [TOP_MAX];
  logic                       cell_beaten[TOP_MAX];

  always_comb begin
    if (top_count_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(top_count_r) > TOP_MAX) begin
      k_eff = KW'(TOP_MAX);
    end else begin
      k_eff = KW'(top_count_r);
    end
  end

  assign n_cur      = (filled_r > k_eff) ? k_eff : filled_r;
  assign fill_nxt   = (n_cur < k_eff) ? n_cur + KW'(1) : k_eff;
  assign accept     = in_ch.valid && in_ch.ready;
  assign cnt_ok     = label_cnt_r < CNT_W'(MAX_LABELS);
  assign insert     = accept && cnt_ok;
  assign new_idx    = tks_pkg::IDX_W'(label_cnt_r);
  assign load_out   = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);
  assign drain_last = (rank_r + KW'(1)) == emit_n_r;

  assign in_ch.ready = (state_r == ST_ACCEPT);

  for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
    tks_pkg::cell_ctl_t ctl;
    logic               prev_b;
    tks_pkg::score_t    prev_s;
    tks_pkg::label_idx_t prev_i;
    tks_pkg::score_t    next_s;
    tks_pkg::label_idx_t next_i;

    assign ctl.insert     = insert;
    assign ctl.shift      = load_out;
    assign ctl.occupied   = KW'(i) < n_cur;
    assign ctl.first_free = KW'(i) == n_cur;
    assign ctl.in_range   = KW'(i) < k_eff;

    if (i == 0) begin : g_head
      assign prev_b = 1'b0;
      assign prev_s = cell_score[0];
      assign prev_i = cell_idx[0];
    end else begin : g_body
      assign prev_b = cell_beaten[i-1];
      assign prev_s = cell_score[i-1];
      assign prev_i = cell_idx[i-1];
    end

    if (i == TOP_MAX - 1) begin : g_tail
      assign next_s = cell_score[i];
      assign next_i = cell_idx[i];
    end else begin : g_inner
      assign next_s = cell_score[i+1];
      assign next_i = cell_idx[i+1];
    end

    tks_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_score   (in_ch.score),
      .new_idx     (new_idx),
      .prev_beaten (prev_b),
      .prev_score  (prev_s),
      .prev_idx    (prev_i),
      .next_score  (next_s),
      .next_idx    (next_i),
      .score       (cell_score[i]),
      .idx         (cell_idx[i]),
      .beaten      (cell_beaten[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= tks_pkg::TOPC_W'(1);
    end else if (cfg_we) begin
      top_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      filled_r    <= '0;
      label_cnt_r <= '0;
      ovf_r       <= 1'b0;
      emit_n_r    <= '0;
      emit_ovf_r  <= 1'b0;
      rank_r      <= '0;
    end else begin
      case (state_r)
        ST_ACCEPT: begin
          if (accept) begin
            if (in_ch.end_of_vector) begin
              filled_r    <= '0;
              label_cnt_r <= '0;
              ovf_r       <= 1'b0;
              emit_n_r    <= cnt_ok ? fill_nxt : n_cur;
              emit_ovf_r  <= ovf_r || !cnt_ok;
              rank_r      <= '0;
              state_r     <= ST_DRAIN;
            end else if (cnt_ok) begin
              filled_r    <= fill_nxt;
              label_cnt_r <= label_cnt_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            rank_r <= rank_r + KW'(1);
            if (drain_last) begin
              state_r <= ST_ACCEPT;
            end
          end
        end
        default: begin
          state_r <= ST_ACCEPT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= cell_idx[0];
      out_rank_r <= tks_pkg::RANK_W'(rank_r);
      out_last_r <= drain_last;
      out_ovf_r  <= emit_ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.label_index = out_idx_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.overflowed  = out_ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= KW'(TOP_MAX))
    else $error("Fill count exceeds the cell chain length.");

  a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
    label_cnt_r <= CNT_W'(MAX_LABELS))
    else $error("Label counter passed its saturation value.");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (emit_n_r != '0) && (rank_r < emit_n_r))
    else $error("Drain rank outside the reported count.");

  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && drain_last) |=> (state_r == ST_ACCEPT) && out_ch.valid && out_ch.last_of_run)
    else $error("Final result beat did not close the vector.");

  a_eov_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_vector) |=> (state_r == ST_DRAIN) && (filled_r == '0))
    else $error("End of vector did not start the drain.");

endmodule
